/* rtl/nfpa_pkg.sv */
// Shared types and constants for the next-fit pool allocator.
`default_nettype none

package nfpa_pkg;

    localparam int POOL_DEPTH = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int LEN_W      = 13;
    localparam int STEP_W     = ADDR_W + 1;
    localparam int BYTES_W    = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  used;
        logic [LEN_W-1:0]  free;
        logic [ADDR_W-1:0] next;
    } hdr_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        hdr_t              wdata;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [ADDR_W-1:0] payload;
    } resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_AREAD,
        ST_AWALK,
        ST_AFRESH,
        ST_APREV,
        ST_FWALK,
        ST_FTGT
    } state_t;

endpackage

`default_nettype wire

/* rtl/nfpa_hdr_ram.sv */
// Block header memory: single port, registered read data.
`default_nettype none

module nfpa_hdr_ram
(
    input  wire logic              clk,
    input  wire nfpa_pkg::mem_req_t req,
    output      nfpa_pkg::hdr_t     rdata
);

    nfpa_pkg::hdr_t mem [nfpa_pkg::POOL_DEPTH];
    nfpa_pkg::hdr_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/nfpa_walker.sv */
// Request sequencer: walks the block list in header memory and edits it.
`default_nettype none

module nfpa_walker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic                           in_op,
    input  wire logic [nfpa_pkg::BYTES_W-1:0]   in_bytes,
    input  wire logic [nfpa_pkg::ADDR_W-1:0]    in_addr,
    input  wire logic [nfpa_pkg::LEN_W-1:0]     pool_units,
    input  wire nfpa_pkg::hdr_t                 rdata,
    output      nfpa_pkg::mem_req_t             mem_req,
    output      nfpa_pkg::resp_t                resp,
    input  wire logic                           resp_ready
);

    localparam int AW = nfpa_pkg::ADDR_W;
    localparam int LW = nfpa_pkg::LEN_W;
    localparam int SW = nfpa_pkg::STEP_W;
    localparam int BYTES_W_SUM = nfpa_pkg::BYTES_W + 1;

    nfpa_pkg::state_t state_reg, state_next;
    logic             resp_pend_reg;
    logic             resp_pend_next;
    logic             started_reg;
    logic [AW-1:0]    recent_reg;
    logic [AW-1:0]    p_reg;
    logic [AW-1:0]    fresh_reg;
    logic [AW-1:0]    target_reg;
    logic [LW-1:0]    need_reg;
    logic [SW-1:0]    steps_reg;
    nfpa_pkg::hdr_t   hold_reg;
    logic             ok_reg;
    logic [AW-1:0]    pay_reg;

    logic [BYTES_W_SUM-1:0] byte_sum;
    logic [LW-1:0]    in_need;
    logic [AW-1:0]    in_target;
    logic             steps_left;
    logic             a_cont;
    logic             a_fit;
    logic             f_cont;
    logic             f_hit;
    logic [LW-1:0]    units_clamped;
    logic             busy;

    assign byte_sum  = BYTES_W_SUM'(in_bytes) + BYTES_W_SUM'(nfpa_pkg::UNIT_BYTES - 1);
    assign in_need   = LW'(byte_sum >> nfpa_pkg::UNIT_SHIFT) + LW'(1);
    assign in_target = in_addr - AW'(1);

    assign steps_left = (steps_reg < SW'(nfpa_pkg::POOL_DEPTH));
    assign a_fit      = (rdata.free >= need_reg);
    assign a_cont     = (rdata.next != recent_reg) && !a_fit && steps_left;
    assign f_hit      = (rdata.next == target_reg);
    assign f_cont     = !f_hit && (rdata.next != recent_reg) && steps_left;

    always_comb
    begin
        units_clamped = pool_units;
        if (pool_units < LW'(2))
        begin
            units_clamped = LW'(2);
        end
        else if (pool_units > LW'(nfpa_pkg::POOL_DEPTH))
        begin
            units_clamped = LW'(nfpa_pkg::POOL_DEPTH);
        end
    end

    assign busy = resp_pend_reg && !resp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfpa_pkg::ST_IDLE:
            begin
                if (in_valid && !busy)
                begin
                    if (in_op == nfpa_pkg::OP_ALLOC)
                    begin
                        state_next = started_reg ? nfpa_pkg::ST_AWALK : nfpa_pkg::ST_INIT;
                    end
                    else if (started_reg && (in_target != '0))
                    begin
                        state_next = nfpa_pkg::ST_FWALK;
                    end
                end
            end
            nfpa_pkg::ST_INIT:   state_next = nfpa_pkg::ST_AREAD;
            nfpa_pkg::ST_AREAD:  state_next = nfpa_pkg::ST_AWALK;
            nfpa_pkg::ST_AWALK:
            begin
                if (!a_cont)
                begin
                    state_next = a_fit ? nfpa_pkg::ST_AFRESH : nfpa_pkg::ST_IDLE;
                end
            end
            nfpa_pkg::ST_AFRESH: state_next = nfpa_pkg::ST_APREV;
            nfpa_pkg::ST_APREV:  state_next = nfpa_pkg::ST_IDLE;
            nfpa_pkg::ST_FWALK:
            begin
                if (!f_cont)
                begin
                    state_next = f_hit ? nfpa_pkg::ST_FTGT : nfpa_pkg::ST_IDLE;
                end
            end
            nfpa_pkg::ST_FTGT:   state_next = nfpa_pkg::ST_IDLE;
            default:             state_next = nfpa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_req = '0;
        in_ready = (state_reg == nfpa_pkg::ST_IDLE) && !busy;
        unique case (state_reg)
            nfpa_pkg::ST_IDLE:
            begin
                if (in_valid && !busy && started_reg
                    && ((in_op == nfpa_pkg::OP_ALLOC) || (in_target != '0)))
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = recent_reg;
                end
            end
            nfpa_pkg::ST_INIT:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = '0;
                mem_req.wdata.used = LW'(1);
                mem_req.wdata.free = units_clamped - LW'(1);
                mem_req.wdata.next = '0;
            end
            nfpa_pkg::ST_AREAD:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = p_reg;
            end
            nfpa_pkg::ST_AWALK:
            begin
                if (a_cont)
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = rdata.next;
                end
            end
            nfpa_pkg::ST_AFRESH:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = fresh_reg;
                mem_req.wdata.used = need_reg;
                mem_req.wdata.free = hold_reg.free - need_reg;
                mem_req.wdata.next = hold_reg.next;
            end
            nfpa_pkg::ST_APREV:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = p_reg;
                mem_req.wdata.used = (fresh_reg == p_reg) ? need_reg : hold_reg.used;
                mem_req.wdata.free = '0;
                mem_req.wdata.next = fresh_reg;
            end
            nfpa_pkg::ST_FWALK:
            begin
                if (f_cont || f_hit)
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = rdata.next;
                end
            end
            nfpa_pkg::ST_FTGT:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = p_reg;
                mem_req.wdata.used = hold_reg.used;
                mem_req.wdata.free = hold_reg.free + rdata.used + rdata.free;
                mem_req.wdata.next = rdata.next;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_comb
    begin
        resp_pend_next = resp_pend_reg && !resp_ready;
        unique case (state_reg)
            nfpa_pkg::ST_IDLE:
            begin
                if (in_valid && !busy && (in_op == nfpa_pkg::OP_FREE)
                    && (!started_reg || (in_target == '0)))
                begin
                    resp_pend_next = 1'b1;
                end
            end
            nfpa_pkg::ST_AWALK:
            begin
                if (!a_cont && !a_fit)
                begin
                    resp_pend_next = 1'b1;
                end
            end
            nfpa_pkg::ST_APREV:
            begin
                resp_pend_next = 1'b1;
            end
            nfpa_pkg::ST_FWALK:
            begin
                if (!f_cont && !f_hit)
                begin
                    resp_pend_next = 1'b1;
                end
            end
            nfpa_pkg::ST_FTGT:
            begin
                resp_pend_next = 1'b1;
            end
            default:
            begin
                resp_pend_next = resp_pend_reg && !resp_ready;
            end
        endcase
    end

    assign resp = {resp_pend_reg, ok_reg, pay_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfpa_pkg::ST_IDLE;
            resp_pend_reg <= 1'b0;
            started_reg   <= 1'b0;
            recent_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            resp_pend_reg <= resp_pend_next;
            unique case (state_reg)
                nfpa_pkg::ST_INIT:
                begin
                    started_reg <= 1'b1;
                    recent_reg  <= '0;
                end
                nfpa_pkg::ST_APREV:
                begin
                    recent_reg <= fresh_reg;
                end
                nfpa_pkg::ST_FTGT:
                begin
                    recent_reg <= p_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            nfpa_pkg::ST_IDLE:
            begin
                if (in_valid && !busy)
                begin
                    need_reg   <= in_need;
                    target_reg <= in_target;
                    p_reg      <= recent_reg;
                    steps_reg  <= '0;
                    ok_reg     <= 1'b0;
                    pay_reg    <= '0;
                end
            end
            nfpa_pkg::ST_INIT:
            begin
                p_reg <= '0;
            end
            nfpa_pkg::ST_AWALK:
            begin
                hold_reg  <= rdata;
                fresh_reg <= p_reg + rdata.used[AW-1:0];
                if (a_cont)
                begin
                    p_reg     <= rdata.next;
                    steps_reg <= steps_reg + SW'(1);
                end
            end
            nfpa_pkg::ST_APREV:
            begin
                ok_reg  <= 1'b1;
                pay_reg <= fresh_reg + AW'(1);
            end
            nfpa_pkg::ST_FWALK:
            begin
                hold_reg <= rdata;
                if (f_cont)
                begin
                    p_reg     <= rdata.next;
                    steps_reg <= steps_reg + SW'(1);
                end
            end
            nfpa_pkg::ST_FTGT:
            begin
                ok_reg <= 1'b1;
            end
            default:
            begin
                ok_reg <= ok_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/next_fit_pool_allocator_top.sv */
// Top level of the next-fit pool allocator: ports, config register, output register.
`default_nettype none

// Each request yields one result word. The block works on one request at a time,
// walking the circular block list one header per cycle through a single-port
// header memory. A walk follows at most 4096 next links; the very first
// allocate also builds the sentinel block. Requests that are refused up front
// (free before any allocate, free of the sentinel) skip the list walk. A
// finished result waits in an output register so the next request can be taken
// while it is pending. pool_units is sampled when the first allocate builds the
// pool; write it only while the block is idle.
module next_fit_pool_allocator_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // byte_count[15:0], block_address[27:16], zero
    input  wire logic        s_tuser,   // operation
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // payload_address[11:0], zero
    output      logic        m_tuser    // ok
);

    localparam int AW = nfpa_pkg::ADDR_W;

    logic [nfpa_pkg::LEN_W-1:0] pool_units_reg;
    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [AW-1:0]              out_pay_reg;
    logic                       resp_ready;
    nfpa_pkg::mem_req_t         mem_req;
    nfpa_pkg::hdr_t             rdata;
    nfpa_pkg::resp_t            resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_units_reg <= nfpa_pkg::LEN_W'(nfpa_pkg::POOL_DEPTH);
        end
        else if (cfg_we)
        begin
            pool_units_reg <= cfg_wdata;
        end
    end

    nfpa_hdr_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    nfpa_walker u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_bytes   (s_tdata[15:0]),
        .in_addr    (s_tdata[27:16]),
        .pool_units (pool_units_reg),
        .rdata      (rdata),
        .mem_req    (mem_req),
        .resp       (resp),
        .resp_ready (resp_ready)
    );

    assign resp_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_ready)
        begin
            out_valid_reg <= resp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_ready && resp.valid)
        begin
            out_ok_reg  <= resp.ok;
            out_pay_reg <= resp.payload;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {4'b0, out_pay_reg};

endmodule

`default_nettype wire

/* rtl/nfpa_checker.sv */
// Port-level checks for the next-fit pool allocator, bound to the top level.
`default_nettype none

module nfpa_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
        else $error("refused result carries a payload address");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] == 4'h0)
        else $error("result word padding is not zero");

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared while a request was in progress");

endmodule

bind next_fit_pool_allocator_top nfpa_checker u_nfpa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/tb_next_fit_pool_allocator_top.sv */
// Self-checking testbench for the next-fit pool allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_next_fit_pool_allocator_top;

    typedef struct packed {
        logic                        ok;
        logic [nfpa_pkg::ADDR_W-1:0] payload;
    } grant_t;

    typedef struct packed {
        logic                        op;
        logic [15:0]                 bytes;
        logic [nfpa_pkg::ADDR_W-1:0] addr;
        logic                        typed;
        logic                        ok;
        logic [nfpa_pkg::ADDR_W-1:0] payload;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // byte_count[15:0], block_address[27:16], zero
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // payload_address[11:0], zero
    logic        m_tuser;   // ok

    logic [nfpa_pkg::LEN_W-1:0]  pool_used [nfpa_pkg::POOL_DEPTH];
    logic [nfpa_pkg::LEN_W-1:0]  pool_free [nfpa_pkg::POOL_DEPTH];
    logic [nfpa_pkg::ADDR_W-1:0] pool_next [nfpa_pkg::POOL_DEPTH];
    int                          pool_cursor;
    bit                          pool_built;
    logic [12:0]                 units_reg;

    grant_t                      grant_q [$];
    grant_t                      grant_head;
    logic [nfpa_pkg::ADDR_W-1:0] live_blocks [$];

    int send_idle;
    int recv_idle;
    int mismatches;
    int n_requests;
    int n_granted;
    int n_released;
    int n_refused;
    int peak_live;

    req_row_t dir_tab [0:19] = '{
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd5,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'hFFFF,  12'd1,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'hFFFF,  12'd0,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'd65488, 12'hFFF,  1'b1, 1'b1, 12'd2},
        '{nfpa_pkg::OP_ALLOC, 16'd0,     12'd0,    1'b1, 1'b1, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'd0,     12'd0,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd0,    1'b1, 1'b1, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd1,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd0,    1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd2,    1'b1, 1'b1, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd4095, 1'b1, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'd1,     12'd0,    1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'd16,    12'd0,    1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'd17,    12'd0,    1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'h8000,  12'd0,    1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd4,    1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'h5555,  12'hAAA,  1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_ALLOC, 16'h2AAA,  12'h555,  1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'h1234,  12'hAAA,  1'b0, 1'b0, 12'd0},
        '{nfpa_pkg::OP_FREE,  16'd0,     12'd2,    1'b0, 1'b0, 12'd0}
    };

    next_fit_pool_allocator_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #1_000_000_000;
        $display("tb_next_fit_pool_allocator_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void predict_outcome(input logic op, input logic [15:0] bytes,
                                            input logic [nfpa_pkg::ADDR_W-1:0] addr,
                                            output logic ok,
                                            output logic [nfpa_pkg::ADDR_W-1:0] pay);
        int need;
        int units;
        int p;
        int prev;
        int fresh;
        int target;
        int steps;
        ok = 1'b0;
        pay = '0;
        steps = 0;
        if (op == nfpa_pkg::OP_ALLOC)
        begin
            need = (int'(bytes) + nfpa_pkg::UNIT_BYTES - 1) / nfpa_pkg::UNIT_BYTES + 1;
            if (!pool_built)
            begin
                units = int'(units_reg);
                if (units < 2)
                    units = 2;
                if (units > nfpa_pkg::POOL_DEPTH)
                    units = nfpa_pkg::POOL_DEPTH;
                pool_used[0] = nfpa_pkg::LEN_W'(1);
                pool_free[0] = nfpa_pkg::LEN_W'(units - 1);
                pool_next[0] = '0;
                pool_cursor = 0;
                pool_built = 1'b1;
            end
            p = pool_cursor;
            while (int'(pool_next[p]) != pool_cursor && int'(pool_free[p]) < need
                   && steps < nfpa_pkg::POOL_DEPTH)
            begin
                p = int'(pool_next[p]);
                steps++;
            end
            if (int'(pool_free[p]) >= need)
            begin
                fresh = (p + int'(pool_used[p])) % nfpa_pkg::POOL_DEPTH;
                pool_used[fresh] = nfpa_pkg::LEN_W'(need);
                pool_free[fresh] = nfpa_pkg::LEN_W'(int'(pool_free[p]) - need);
                pool_next[fresh] = pool_next[p];
                pool_next[p] = nfpa_pkg::ADDR_W'(fresh);
                pool_free[p] = '0;
                pool_cursor = fresh;
                ok = 1'b1;
                pay = nfpa_pkg::ADDR_W'((fresh + 1) % nfpa_pkg::POOL_DEPTH);
            end
        end
        else
        begin
            target = (int'(addr) + nfpa_pkg::POOL_DEPTH - 1) % nfpa_pkg::POOL_DEPTH;
            if (pool_built && target != 0)
            begin
                prev = pool_cursor;
                p = int'(pool_next[prev]);
                while (p != target && p != pool_cursor && steps < nfpa_pkg::POOL_DEPTH)
                begin
                    prev = p;
                    p = int'(pool_next[prev]);
                    steps++;
                end
                if (p == target)
                begin
                    pool_free[prev] = nfpa_pkg::LEN_W'(int'(pool_free[prev])
                                      + int'(pool_used[p]) + int'(pool_free[p]));
                    pool_next[prev] = pool_next[p];
                    pool_cursor = prev;
                    ok = 1'b1;
                end
            end
        end
    endfunction

    task automatic issue(input logic op, input logic [15:0] bytes,
                         input logic [nfpa_pkg::ADDR_W-1:0] addr,
                         input logic typed, input logic t_ok,
                         input logic [nfpa_pkg::ADDR_W-1:0] t_pay);
        logic                        ok;
        logic [nfpa_pkg::ADDR_W-1:0] pay;
        int                          i;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, addr, bytes};
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_outcome(op, bytes, addr, ok, pay);
        if (typed)
            grant_q.push_back('{t_ok, t_pay});
        else
            grant_q.push_back('{ok, pay});
        n_requests++;
        if (!ok)
            n_refused++;
        else if (op == nfpa_pkg::OP_ALLOC)
        begin
            n_granted++;
            live_blocks.push_back(pay);
            if (live_blocks.size() > peak_live)
                peak_live = live_blocks.size();
        end
        else
        begin
            n_released++;
            for (i = 0; i < live_blocks.size(); i++)
            begin
                if (live_blocks[i] == addr)
                begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_units(input logic [12:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        units_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grant_q.size() == 0)
            begin
                report_mismatch("result word with none pending, ok", int'(m_tuser), 0);
            end
            else
            begin
                grant_head = grant_q.pop_front();
                if (m_tuser !== grant_head.ok)
                    report_mismatch("ok", int'(m_tuser), int'(grant_head.ok));
                if (m_tdata[nfpa_pkg::ADDR_W-1:0] !== grant_head.payload)
                    report_mismatch("payload_address", int'(m_tdata[nfpa_pkg::ADDR_W-1:0]),
                                    int'(grant_head.payload));
            end
        end
    end

    initial
    begin
        int                          i;
        int                          phase;
        int                          k;
        int                          r;
        logic                        op;
        logic [15:0]                 bytes;
        logic [nfpa_pkg::ADDR_W-1:0] addr;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        send_idle = 12;
        recv_idle = 70;
        mismatches = 0;
        n_requests = 0;
        n_granted = 0;
        n_released = 0;
        n_refused = 0;
        peak_live = 0;
        pool_built = 1'b0;
        pool_cursor = 0;
        units_reg = 13'd4096;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // below-range and out-of-range values; the last one sizes the pool
        write_units(13'd0);
        write_units(13'd1);
        write_units(13'h1FFF);

        for (i = 0; i < 20; i++)
            issue(dir_tab[i].op, dir_tab[i].bytes, dir_tab[i].addr,
                  dir_tab[i].typed, dir_tab[i].ok, dir_tab[i].payload);

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                write_units(phase == 1 ? 13'd2 : 13'd4096);
            end
            send_idle = (phase == 0) ? 12 : (phase == 1) ? 70 : 0;
            recv_idle = (phase == 0) ? 70 : (phase == 1) ? 12 : 0;
            for (k = 0; k < 534; k++)
            begin
                if (k == 250)
                    wait_drained();
                addr = nfpa_pkg::ADDR_W'($urandom_range(nfpa_pkg::POOL_DEPTH - 1));
                bytes = 16'($urandom_range(16'hFFFF));
                if (live_blocks.size() == 0)
                    op = ($urandom_range(99) < 85) ? nfpa_pkg::OP_ALLOC : nfpa_pkg::OP_FREE;
                else if (live_blocks.size() < 48)
                    op = ($urandom_range(99) < 60) ? nfpa_pkg::OP_ALLOC : nfpa_pkg::OP_FREE;
                else
                    op = ($urandom_range(99) < 35) ? nfpa_pkg::OP_ALLOC : nfpa_pkg::OP_FREE;
                if (op == nfpa_pkg::OP_ALLOC)
                begin
                    r = int'($urandom_range(99));
                    if (r < 70)
                        bytes = 16'($urandom_range(255));
                    else if (r < 92)
                        bytes = 16'($urandom_range(4095, 256));
                    else if (r < 97)
                        bytes = 16'($urandom_range(16'hFFFF, 4096));
                end
                else if (live_blocks.size() != 0 && $urandom_range(99) < 80)
                begin
                    addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
                end
                issue(op, bytes, addr, 1'b0, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(negedge clk);
        repeat (nfpa_pkg::POOL_DEPTH + 8) @(negedge clk);

        $display("covered %0d requests: %0d granted, %0d released, %0d refused",
                 n_requests, n_granted, n_released, n_refused);
        $display("peak of %0d live blocks, three idle mixes on both sides", peak_live);
        if (mismatches == 0)
        begin
            $display("tb_next_fit_pool_allocator_top OK");
        end
        else
        begin
            $display("tb_next_fit_pool_allocator_top NOT OK");
        end
        $finish;
    end

endmodule
